// ----- design/stp_pkg.sv -----
// Shared constants, codes and types for the stereo timestamp pairing core.
package stp_pkg;

  localparam int TRIGGER_DEPTH = 8;
  localparam int TAG_BITS      = 8;

  localparam int TS_W       = 63;
  localparam int TAG_W      = 8;
  localparam int DELAY_W    = 30;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  localparam int RING_AW = (TRIGGER_DEPTH > 1) ? $clog2(TRIGGER_DEPTH) : 1;
  localparam int FILL_W  = $clog2(TRIGGER_DEPTH + 1);

  localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((17'(1) << TAG_BITS) - 17'(1));

  // request kinds
  localparam logic [1:0] REQ_LEFT  = 2'd0;
  localparam logic [1:0] REQ_RIGHT = 2'd1;
  localparam logic [1:0] REQ_TRIG  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // result codes
  localparam logic [2:0] EV_PAIR     = 3'd0;
  localparam logic [2:0] EV_STORED   = 3'd1;
  localparam logic [2:0] EV_OLD_DROP = 3'd2;
  localparam logic [2:0] EV_NEW_DROP = 3'd3;
  localparam logic [2:0] EV_TRIGGER  = 3'd4;

  // stamp strategies
  localparam logic [1:0] STRAT_EARLIEST = 2'd0;
  localparam logic [1:0] STRAT_AVERAGE  = 2'd1;
  localparam logic [1:0] STRAT_LEFT     = 2'd2;
  localparam logic [1:0] STRAT_RIGHT    = 2'd3;

  // register indexes
  localparam logic [1:0] REG_MAX_DELAY = 2'd0;
  localparam logic [1:0] REG_STRATEGY  = 2'd1;
  localparam logic [1:0] REG_USE_TRIG  = 2'd2;
  localparam logic [1:0] REG_WINDOW    = 2'd3;

  localparam logic [DELAY_W-1:0] MAX_DELAY_RST = DELAY_W'(25000000);
  localparam logic [DELAY_W-1:0] WINDOW_RST    = DELAY_W'(60000000);

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] sum;
    logic        borrow;
  } alu_rsp_t;

  typedef struct packed {
    logic              rd_en;
    logic [FILL_W-1:0] rd_ofs;
    logic              wr_en;
  } ring_ctl_t;

endpackage

// ----- design/stereo_timestamp_pairing_core.sv -----
// Top level: stereo frame pairing sequencer around one shared adder and a trigger ring.
//
// Input beats carry a left frame, right frame or trigger time (in_tuser) with a
// 63-bit ns timestamp and buffer tag. Each left, right or trigger beat gives one
// result beat; a beat of the undefined kind is absorbed with no result.
// in_tready is high only while the sequencer is idle; one beat is worked at a time.
// Trigger beats and frames that store or drop without comparison go from decode
// straight to the result; other frames take the difference, absolute value and
// delay compare, and a pair then the stamp step and, when trigger stamping is on,
// a scan of the ring: each entry takes a ring read and a subtract, a qualifying
// one also a window compare and, if a trigger was already found, a best-distance
// compare, all arithmetic on the one shared 64-bit adder. The block is ready again
// the cycle after the result is loaded.
// The result sits in an output register; if the receiver stalls, the next beat is
// still accepted and worked, and the sequencer holds its result until the output
// register frees up.
// Reset (rst_n low, synchronous) clears the pending frame, the trigger ring fill
// and pointer, the output valid and loads the register defaults.
// Registers (APB, byte address 4*i): max pair delay, stamp strategy, trigger
// mode, trigger window. Write them only while the block is idle.
module stereo_timestamp_pairing_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [62:0] timestamp_ns, [70:63] frame_tag, [71] zero
  input  logic [stp_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] req_type
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] left_tag, [15:8] right_tag, [78:16] pair_stamp_ns,
  // [79] stamp_from_trigger, [80] dropped_side, [87:81] zero
  output logic [stp_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [2:0] event_code
  output logic [2:0]                        out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [stp_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [stp_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [stp_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_ABS   = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_STAMP = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_TSUB  = 4'd6;
  localparam logic [3:0] S_TWIN  = 4'd7;
  localparam logic [3:0] S_TBEST = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  localparam int TS_W = stp_pkg::TS_W;

  // configuration
  logic [stp_pkg::DELAY_W-1:0] max_delay_r, window_r;
  logic [1:0]                  strategy_r;
  logic                        use_trig_r;
  logic                        cfg_we;

  // sequencer and work registers
  logic [3:0]                  state_r, state_nxt;
  logic [1:0]                  req_r;
  logic [TS_W-1:0]             ts_r;
  logic [stp_pkg::TAG_W-1:0]   tag_r;
  logic                        pend_valid_r, pend_valid_nxt;
  logic                        pend_right_r;
  logic [TS_W-1:0]             pend_stamp_r;
  logic [stp_pkg::TAG_W-1:0]   pend_tag_r;
  logic [63:0]                 acc_r, acc_nxt;
  logic                        lt_r, lt_nxt;
  logic [TS_W-1:0]             st_r, st_nxt;
  logic [TS_W-1:0]             d_r, d_nxt;
  logic [TS_W-1:0]             best_r, best_nxt;
  logic [TS_W-1:0]             bestd_r, bestd_nxt;
  logic                        found_r, found_nxt;
  logic [stp_pkg::FILL_W-1:0]  k_r, k_nxt;
  logic [2:0]                  ev_r, ev_nxt;
  logic                        side_r, side_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [stp_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [2:0]                  out_tuser_r, out_tuser_nxt;

  logic                        in_fire, fin_go, is_right;
  stp_pkg::alu_req_t           alu_req;
  stp_pkg::alu_rsp_t           alu_rsp;
  stp_pkg::ring_ctl_t          ring_ctl;
  logic [TS_W-1:0]             ring_data;
  logic [stp_pkg::FILL_W-1:0]  ring_fill;
  logic                        trig_ok;

  stp_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  stp_trig_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ring_ctl),
    .wr_data (ts_r),
    .rd_data (ring_data),
    .fill    (ring_fill)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign is_right  = (req_r == stp_pkg::REQ_RIGHT);
  assign fin_go    = (state_r == S_FIN) & (~out_valid_r | out_tready);
  assign trig_ok   = (ring_data != '0) & ~alu_rsp.borrow & (alu_rsp.sum != '0);

  always_comb begin
    state_nxt      = state_r;
    pend_valid_nxt = pend_valid_r;
    acc_nxt        = acc_r;
    lt_nxt         = lt_r;
    st_nxt         = st_r;
    d_nxt          = d_r;
    best_nxt       = best_r;
    bestd_nxt      = bestd_r;
    found_nxt      = found_r;
    k_nxt          = k_r;
    ev_nxt         = ev_r;
    side_nxt       = side_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    alu_req.a      = {1'b0, ts_r};
    alu_req.b      = {1'b0, pend_stamp_r};
    alu_req.sub    = 1'b1;
    ring_ctl.rd_en  = 1'b0;
    ring_ctl.rd_ofs = k_r;
    ring_ctl.wr_en  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        side_nxt = 1'b0;
        if (req_r == stp_pkg::REQ_NONE) begin
          state_nxt = S_IDLE;
        end else if (req_r == stp_pkg::REQ_TRIG) begin
          ev_nxt    = stp_pkg::EV_TRIGGER;
          state_nxt = S_FIN;
        end else if (!pend_valid_r) begin
          ev_nxt    = stp_pkg::EV_STORED;
          state_nxt = S_FIN;
        end else if (pend_right_r == is_right) begin
          ev_nxt    = stp_pkg::EV_OLD_DROP;
          side_nxt  = pend_right_r;
          state_nxt = S_FIN;
        end else begin
          acc_nxt   = alu_rsp.sum;
          lt_nxt    = alu_rsp.borrow;
          state_nxt = S_ABS;
        end
      end
      S_ABS: begin
        alu_req.a = {1'b0, pend_stamp_r};
        alu_req.b = {1'b0, ts_r};
        if (lt_r) begin
          acc_nxt = alu_rsp.sum;
        end
        state_nxt = S_CMP;
      end
      S_CMP: begin
        alu_req.a = acc_r;
        alu_req.b = 64'(max_delay_r);
        if (alu_rsp.borrow) begin
          ev_nxt    = stp_pkg::EV_PAIR;
          state_nxt = S_STAMP;
        end else if (!lt_r && acc_r != '0) begin
          ev_nxt    = stp_pkg::EV_OLD_DROP;
          side_nxt  = pend_right_r;
          state_nxt = S_FIN;
        end else begin
          ev_nxt    = stp_pkg::EV_NEW_DROP;
          side_nxt  = is_right;
          state_nxt = S_FIN;
        end
      end
      S_STAMP: begin
        alu_req.sub = 1'b0;
        unique case (strategy_r)
          stp_pkg::STRAT_EARLIEST: st_nxt = lt_r ? ts_r : pend_stamp_r;
          stp_pkg::STRAT_AVERAGE:  st_nxt = alu_rsp.sum[63:1];
          stp_pkg::STRAT_LEFT:     st_nxt = is_right ? pend_stamp_r : ts_r;
          stp_pkg::STRAT_RIGHT:    st_nxt = is_right ? ts_r : pend_stamp_r;
          default:                 st_nxt = ts_r;
        endcase
        found_nxt = 1'b0;
        k_nxt     = '0;
        state_nxt = use_trig_r ? S_RD : S_FIN;
      end
      S_RD: begin
        if (k_r == ring_fill) begin
          state_nxt = S_FIN;
        end else begin
          ring_ctl.rd_en = 1'b1;
          k_nxt          = k_r + stp_pkg::FILL_W'(1);
          state_nxt      = S_TSUB;
        end
      end
      S_TSUB: begin
        alu_req.a = {1'b0, st_r};
        alu_req.b = {1'b0, ring_data};
        d_nxt     = alu_rsp.sum[TS_W-1:0];
        state_nxt = trig_ok ? S_TWIN : S_RD;
      end
      S_TWIN: begin
        alu_req.a = {1'b0, d_r};
        alu_req.b = 64'(window_r);
        state_nxt = S_RD;
        if (alu_rsp.borrow) begin
          if (found_r) begin
            state_nxt = S_TBEST;
          end else begin
            found_nxt = 1'b1;
            best_nxt  = ring_data;
            bestd_nxt = d_r;
          end
        end
      end
      S_TBEST: begin
        alu_req.a = {1'b0, d_r};
        alu_req.b = {1'b0, bestd_r};
        if (alu_rsp.borrow) begin
          best_nxt  = ring_data;
          bestd_nxt = d_r;
        end
        state_nxt = S_RD;
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          out_tuser_nxt = ev_r;
          out_tdata_nxt = '0;
          out_tdata_nxt[80] = side_r;
          unique case (ev_r)
            stp_pkg::EV_PAIR: begin
              out_tdata_nxt[7:0]   = is_right ? pend_tag_r : tag_r;
              out_tdata_nxt[15:8]  = is_right ? tag_r : pend_tag_r;
              out_tdata_nxt[78:16] = found_r ? best_r : st_r;
              out_tdata_nxt[79]    = found_r;
              pend_valid_nxt       = 1'b0;
            end
            stp_pkg::EV_STORED, stp_pkg::EV_OLD_DROP: begin
              pend_valid_nxt = 1'b1;
            end
            stp_pkg::EV_TRIGGER: begin
              ring_ctl.wr_en = 1'b1;
            end
            default: begin
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_tuser;
      ts_r  <= in_tdata[62:0];
      tag_r <= in_tdata[70:63] & stp_pkg::TAG_MASK;
    end
    if (fin_go && (ev_r == stp_pkg::EV_STORED || ev_r == stp_pkg::EV_OLD_DROP)) begin
      pend_right_r <= is_right;
      pend_stamp_r <= ts_r;
      pend_tag_r   <= tag_r;
    end
    acc_r       <= acc_nxt;
    lt_r        <= lt_nxt;
    st_r        <= st_nxt;
    d_r         <= d_nxt;
    best_r      <= best_nxt;
    bestd_r     <= bestd_nxt;
    found_r     <= found_nxt;
    k_r         <= k_nxt;
    ev_r        <= ev_nxt;
    side_r      <= side_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  // configuration registers
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delay_r <= stp_pkg::MAX_DELAY_RST;
      strategy_r  <= stp_pkg::STRAT_EARLIEST;
      use_trig_r  <= 1'b0;
      window_r    <= stp_pkg::WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_paddr[3:2])
        stp_pkg::REG_MAX_DELAY: max_delay_r <= cfg_pwdata[stp_pkg::DELAY_W-1:0];
        stp_pkg::REG_STRATEGY:  strategy_r  <= cfg_pwdata[1:0];
        stp_pkg::REG_USE_TRIG:  use_trig_r  <= cfg_pwdata[0];
        stp_pkg::REG_WINDOW:    window_r    <= cfg_pwdata[stp_pkg::DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      stp_pkg::REG_MAX_DELAY: cfg_prdata = stp_pkg::CFG_DW'(max_delay_r);
      stp_pkg::REG_STRATEGY:  cfg_prdata = stp_pkg::CFG_DW'(strategy_r);
      stp_pkg::REG_USE_TRIG:  cfg_prdata = stp_pkg::CFG_DW'(use_trig_r);
      stp_pkg::REG_WINDOW:    cfg_prdata = stp_pkg::CFG_DW'(window_r);
      default:                cfg_prdata = '0;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_pair_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && ev_r == stp_pkg::EV_PAIR) |=> !pend_valid_r)
    else $error("pending frame survived a pair");

  a_store_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && (ev_r == stp_pkg::EV_STORED || ev_r == stp_pkg::EV_OLD_DROP))
      |=> pend_valid_r && pend_stamp_r == $past(ts_r))
    else $error("new frame not held as pending");

  a_trig_stamp_only_in_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[79]) |-> (use_trig_r && out_tuser == stp_pkg::EV_PAIR))
    else $error("trigger stamp outside trigger mode or pair");

endmodule

// ----- design/stp_alu.sv -----
// Shared 64-bit add/subtract unit with borrow flag.
module stp_alu (
  input  stp_pkg::alu_req_t req,
  output stp_pkg::alu_rsp_t rsp
);

  logic [63:0] b_x;
  logic [64:0] full;

  assign b_x  = req.sub ? ~req.b : req.b;
  assign full = {1'b0, req.a} + {1'b0, b_x} + 65'(req.sub);

  assign rsp.sum    = full[63:0];
  assign rsp.borrow = req.sub & ~full[64];

endmodule

// ----- design/stp_trig_ring.sv -----
// Trigger time ring: storage, fill count, oldest pointer and registered read port.
module stp_trig_ring (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stp_pkg::ring_ctl_t            ctl,
  input  logic [stp_pkg::TS_W-1:0]      wr_data,
  output logic [stp_pkg::TS_W-1:0]      rd_data,
  output logic [stp_pkg::FILL_W-1:0]    fill
);

  localparam int SUM_W = stp_pkg::RING_AW + 1;

  logic [stp_pkg::TS_W-1:0]    mem [stp_pkg::TRIGGER_DEPTH];
  logic [stp_pkg::TS_W-1:0]    rd_data_r;
  logic [stp_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  logic [stp_pkg::RING_AW-1:0] oldest_r, oldest_nxt;
  logic [SUM_W-1:0]            rd_sum, wr_sum;
  logic [stp_pkg::RING_AW-1:0] rd_addr, wr_addr;
  logic                        full;

  assign full = (fill_r == stp_pkg::FILL_W'(stp_pkg::TRIGGER_DEPTH));

  always_comb begin
    rd_sum = SUM_W'(oldest_r) + SUM_W'(ctl.rd_ofs);
    if (rd_sum >= SUM_W'(stp_pkg::TRIGGER_DEPTH)) begin
      rd_sum = rd_sum - SUM_W'(stp_pkg::TRIGGER_DEPTH);
    end
    rd_addr = stp_pkg::RING_AW'(rd_sum);
  end

  always_comb begin
    wr_sum = SUM_W'(oldest_r) + SUM_W'(fill_r);
    if (wr_sum >= SUM_W'(stp_pkg::TRIGGER_DEPTH)) begin
      wr_sum = wr_sum - SUM_W'(stp_pkg::TRIGGER_DEPTH);
    end
    wr_addr = full ? oldest_r : stp_pkg::RING_AW'(wr_sum);
  end

  always_comb begin
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    if (ctl.wr_en) begin
      if (full) begin
        if (oldest_r == stp_pkg::RING_AW'(stp_pkg::TRIGGER_DEPTH - 1)) begin
          oldest_nxt = '0;
        end else begin
          oldest_nxt = oldest_r + stp_pkg::RING_AW'(1);
        end
      end else begin
        fill_nxt = fill_r + stp_pkg::FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      oldest_r <= '0;
    end else begin
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign fill    = fill_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= stp_pkg::FILL_W'(stp_pkg::TRIGGER_DEPTH))
    else $error("trigger fill count above depth");

  a_oldest_moves_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> oldest_r == '0)
    else $error("oldest pointer moved before ring filled");

  a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
    full |=> full)
    else $error("full trigger ring lost entries");

endmodule

// ----- tb/stereo_timestamp_pairing_core_tb.sv -----
// Self-checking testbench for the stereo timestamp pairing core.
module stereo_timestamp_pairing_core_tb;
  import stp_pkg::*;

  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 225;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 500;
  localparam int HOLD_AFTER     = 600;
  localparam int QUIET_LIMIT    = 4000;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic [2:0]      code;
    logic [TAG_W-1:0] left_tag;
    logic [TAG_W-1:0] right_tag;
    logic [TS_W-1:0] stamp;
    logic            from_trig;
    logic            drop_side;
  } pair_event_t;

  class pairing_scoreboard;
    logic [DELAY_W-1:0] max_delay;
    logic [1:0]         strategy;
    logic               use_trig;
    logic [DELAY_W-1:0] window;

    logic             held_valid;
    logic             held_right;
    logic [TS_W-1:0]  held_stamp;
    logic [TAG_W-1:0] held_tag;
    logic [TS_W-1:0]  trig_ring [TRIGGER_DEPTH];
    int               trig_count;
    int               trig_head;

    pair_event_t awaited_events[$];
    int          errors;
    int          checked;

    function new();
      max_delay  = MAX_DELAY_RST;
      strategy   = STRAT_EARLIEST;
      use_trig   = 1'b0;
      window     = WINDOW_RST;
      held_valid = 1'b0;
      held_right = 1'b0;
      held_stamp = '0;
      held_tag   = '0;
      trig_count = 0;
      trig_head  = 0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void apply_register(logic [1:0] idx, logic [CFG_DW-1:0] value);
      case (idx)
        REG_MAX_DELAY: max_delay = value[DELAY_W-1:0];
        REG_STRATEGY:  strategy  = value[1:0];
        REG_USE_TRIG:  use_trig  = value[0];
        REG_WINDOW:    window    = value[DELAY_W-1:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return awaited_events.size();
    endfunction

    function void add_awaited(pair_event_t ev);
      awaited_events.insert(awaited_events.size(), ev);
    endfunction

    function logic [63:0] unified_stamp(logic [63:0] lt, logic [63:0] rt);
      case (strategy)
        STRAT_AVERAGE: return (lt + rt) >> 1;
        STRAT_LEFT:    return lt;
        STRAT_RIGHT:   return rt;
        default:       return (lt < rt) ? lt : rt;
      endcase
    endfunction

    // nearest nonzero trigger strictly before the stamp and inside the window
    function bit nearest_trigger(logic [63:0] st, output logic [63:0] best);
      logic [63:0] t;
      logic [63:0] d;
      logic [63:0] best_d;
      bit          found;
      found  = 1'b0;
      best_d = '0;
      best   = '0;
      for (int k = 0; k < trig_count; k++) begin
        t = 64'(trig_ring[(trig_head + k) % TRIGGER_DEPTH]);
        if (t == 0 || t >= st) continue;
        d = st - t;
        if (d < 64'(window) && (!found || d < best_d)) begin
          found  = 1'b1;
          best_d = d;
          best   = t;
        end
      end
      return found;
    endfunction

    function void note_request(logic [1:0] kind, logic [TS_W-1:0] ts, logic [TAG_W-1:0] raw_tag);
      pair_event_t      ev;
      logic [TAG_W-1:0] tag;
      logic             is_right;
      logic [63:0]      gap;
      logic [63:0]      lt;
      logic [63:0]      rt;
      logic [63:0]      st;
      logic [63:0]      trig_t;
      bit               hit;
      if (kind == REQ_NONE) return;
      ev  = '0;
      tag = raw_tag & TAG_MASK;
      if (kind == REQ_TRIG) begin
        if (trig_count < TRIGGER_DEPTH) begin
          trig_ring[(trig_head + trig_count) % TRIGGER_DEPTH] = ts;
          trig_count++;
        end else begin
          trig_ring[trig_head] = ts;
          trig_head = (trig_head + 1) % TRIGGER_DEPTH;
        end
        ev.code = EV_TRIGGER;
        add_awaited(ev);
        return;
      end
      is_right = (kind == REQ_RIGHT);
      if (!held_valid) begin
        ev.code = EV_STORED;
      end else if (held_right == is_right) begin
        ev.code      = EV_OLD_DROP;
        ev.drop_side = held_right;
      end else begin
        gap = (ts > held_stamp) ? 64'(ts) - 64'(held_stamp) : 64'(held_stamp) - 64'(ts);
        if (gap < 64'(max_delay)) begin
          lt  = is_right ? 64'(held_stamp) : 64'(ts);
          rt  = is_right ? 64'(ts) : 64'(held_stamp);
          st  = unified_stamp(lt, rt);
          hit = 1'b0;
          if (use_trig) hit = nearest_trigger(st, trig_t);
          ev.code      = EV_PAIR;
          ev.left_tag  = is_right ? held_tag : tag;
          ev.right_tag = is_right ? tag : held_tag;
          ev.stamp     = hit ? trig_t[TS_W-1:0] : st[TS_W-1:0];
          ev.from_trig = hit;
          held_valid   = 1'b0;
          add_awaited(ev);
          return;
        end
        if (held_stamp < ts) begin
          ev.code      = EV_OLD_DROP;
          ev.drop_side = held_right;
        end else begin
          ev.code      = EV_NEW_DROP;
          ev.drop_side = is_right;
          add_awaited(ev);
          return;
        end
      end
      held_valid = 1'b1;
      held_right = is_right;
      held_stamp = ts;
      held_tag   = tag;
      add_awaited(ev);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTED) $display("mismatch at result %0d: %s", checked, msg);
      errors++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_event(logic [2:0] code, logic [OUT_DATA_W-1:0] data);
      pair_event_t want;
      if (awaited_events.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, event_code %0d", code));
        return;
      end
      want = awaited_events[0];
      awaited_events.delete(0);
      compare_field("event_code", 64'(code), 64'(want.code));
      compare_field("left_tag", 64'(data[7:0]), 64'(want.left_tag));
      compare_field("right_tag", 64'(data[15:8]), 64'(want.right_tag));
      compare_field("pair_stamp_ns", 64'(data[16 +: TS_W]), 64'(want.stamp));
      compare_field("stamp_from_trigger", 64'(data[79]), 64'(want.from_trig));
      compare_field("dropped_side", 64'(data[80]), 64'(want.drop_side));
      checked++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_AW-1:0]     cfg_paddr;
  logic [CFG_DW-1:0]     cfg_pwdata;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  pairing_scoreboard sb;
  bit burst_mode = 1'b0;
  int results_seen = 0;
  int quiet_cycles = 0;

  stereo_timestamp_pairing_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(in_tuser, in_tdata[TS_W-1:0], in_tdata[TS_W +: TAG_W]);
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      sb.check_event(out_tuser, out_tdata);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off
  initial begin
    bit held_off;
    held_off   = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
      end
      out_tready <= burst_mode || ($urandom_range(99) >= 35);
    end
  end

  task automatic send_beat(input logic [1:0] kind, input logic [TS_W-1:0] ts,
                           input logic [TAG_W-1:0] tag);
    @(negedge clk);
    while (!burst_mode && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_DATA_W'({tag, ts});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic quiesce();
    release_input();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.apply_register(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic run_directed();
    logic [TS_W-1:0] far;
    far = '1;
    send_beat(REQ_NONE, 63'h5555_5555_5555_5555, 8'hC3);
    send_beat(REQ_LEFT, 63'd1000, 8'h00);
    send_beat(REQ_LEFT, 63'd2000, 8'hFF);
    send_beat(REQ_RIGHT, 63'd25_002_000, 8'h5A);  // gap equals limit
    send_beat(REQ_LEFT, 63'd10, 8'h01);           // older than pending
    send_beat(REQ_LEFT, 63'd25_001_999, 8'hA5);
    send_beat(REQ_LEFT, 63'd0, 8'h00);
    send_beat(REQ_RIGHT, 63'd0, 8'hFF);
    send_beat(REQ_LEFT, far, 8'hFF);
    send_beat(REQ_RIGHT, far - 63'd1, 8'h80);
    quiesce();
    write_reg(REG_USE_TRIG, 32'd1);
    write_reg(REG_STRATEGY, CFG_DW'(STRAT_AVERAGE));
    send_beat(REQ_TRIG, 63'd0, 8'h00);            // zero trigger is invalid
    send_beat(REQ_TRIG, 63'd5_000_000, 8'h11);
    send_beat(REQ_TRIG, 63'd5_000_000, 8'h22);    // tie on distance
    send_beat(REQ_LEFT, 63'd5_000_100, 8'h33);
    send_beat(REQ_RIGHT, 63'd5_000_300, 8'h44);
    send_beat(REQ_RIGHT, 63'd1_001, 8'h55);
    send_beat(REQ_LEFT, 63'd1_000, 8'h66);        // no trigger before stamp
    for (int k = 1; k <= 6; k++)
      send_beat(REQ_TRIG, 63'(k * 10_000_000), 8'(k));
    send_beat(REQ_LEFT, 63'd70_000_050, 8'h77);  // ring wrapped
    send_beat(REQ_RIGHT, 63'd70_000_000, 8'h88);
  endtask

  task automatic send_random_traffic(input int count);
    logic [TS_W-1:0] now;
    logic [TS_W-1:0] tt;
    logic [TS_W-1:0] lt;
    logic [TS_W-1:0] rt;
    logic [1:0]      kind;
    int unsigned     dmax;
    int unsigned     w;
    int unsigned     j;
    int              shape;
    int              sent;
    now  = TS_W'({$urandom(), $urandom()} >> 2);
    sent = 0;
    while (sent < count) begin
      dmax  = sb.max_delay;
      w     = sb.window;
      shape = $urandom_range(99);
      if (shape < 12) begin
        kind = 2'($urandom_range(3));
        send_beat(kind, TS_W'({$urandom(), $urandom()}), 8'($urandom()));
        if (kind != REQ_NONE) sent++;
      end else begin
        now += TS_W'(2 * dmax) + TS_W'($urandom_range(1, 50_000_000));
        repeat ($urandom_range(2)) begin
          tt = ($urandom_range(99) < 4) ? '0 : now - TS_W'($urandom_range(0, w + w / 4 + 2));
          send_beat(REQ_TRIG, tt, 8'($urandom()));
          sent++;
        end
        if ($urandom_range(99) < 80) begin
          j = $urandom_range(0, (dmax > 0) ? dmax - 1 : 0);
        end else begin
          j = $urandom_range(0, 2 * dmax + 2);
        end
        lt = now;
        rt = $urandom_range(1) ? now + TS_W'(j) : now - TS_W'(j);
        if (shape < 90) begin
          if ($urandom_range(1)) begin
            send_beat(REQ_LEFT, lt, 8'($urandom()));
            send_beat(REQ_RIGHT, rt, 8'($urandom()));
          end else begin
            send_beat(REQ_RIGHT, rt, 8'($urandom()));
            send_beat(REQ_LEFT, lt, 8'($urandom()));
          end
          sent += 2;
        end else if (shape < 95) begin
          send_beat($urandom_range(1) ? REQ_RIGHT : REQ_LEFT, lt, 8'($urandom()));
          sent++;
        end else begin
          send_beat(REQ_LEFT, lt, 8'($urandom()));
          send_beat(REQ_LEFT, rt, 8'($urandom()));
          sent += 2;
        end
      end
    end
  endtask

  initial begin
    logic [CFG_DW-1:0] delay_v;
    logic [CFG_DW-1:0] strat_v;
    logic [CFG_DW-1:0] trig_v;
    logic [CFG_DW-1:0] window_v;
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_LEFT;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      case (p)
        0: begin
          delay_v = CFG_DW'(MAX_DELAY_RST); strat_v = CFG_DW'(STRAT_EARLIEST);
          trig_v = 0; window_v = CFG_DW'(WINDOW_RST);
        end
        1: begin
          delay_v = 32'h3FFF_FFFF; strat_v = CFG_DW'(STRAT_AVERAGE);
          trig_v = 1; window_v = 32'h3FFF_FFFF;
        end
        2: begin
          delay_v = 0; strat_v = CFG_DW'(STRAT_LEFT); trig_v = 1; window_v = 1;
        end
        3: begin
          delay_v = 25_000_000; strat_v = CFG_DW'(STRAT_RIGHT); trig_v = 1; window_v = 0;
        end
        4: begin
          delay_v = 20_000_000; strat_v = CFG_DW'(STRAT_AVERAGE);
          trig_v = 1; window_v = 60_000_000;
        end
        default: begin
          // upper bits beyond the register width are junk on purpose
          delay_v  = $urandom_range(0, 40_000_000) | ($urandom() & 32'hC000_0000);
          strat_v  = $urandom();
          trig_v   = $urandom();
          window_v = $urandom_range(0, 80_000_000) | ($urandom() & 32'hC000_0000);
        end
      endcase
      write_reg(REG_MAX_DELAY, delay_v);
      write_reg(REG_STRATEGY, strat_v);
      write_reg(REG_USE_TRIG, trig_v);
      write_reg(REG_WINDOW, window_v);
      burst_mode = (p == 0);
      if (p == 5) begin
        send_random_traffic(PHASE_ITEMS / 2);
        quiesce();
        send_random_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        send_random_traffic(PHASE_ITEMS);
      end
    end

    quiesce();
    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.outstanding()));
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
